[hdl/mwo_pkg.sv]
// Shared types, constants and the quarter-wave sine table of the oscillator.
package mwo_pkg;

   // Phase accumulator width and quarter-wave table depth (power of two)
   localparam int PHASE_BITS         = 32;
   localparam int SINE_QUARTER_DEPTH = 256;
   localparam int SINE_IDX_W         = $clog2(SINE_QUARTER_DEPTH);

   // Table generation constants: pi/2 and 1.0 in Q30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   // Galois LFSR feedback mask and seed
   localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
   localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

   // Sample limits in Q1.15
   localparam logic [15:0] SAMPLE_MAX = 16'h7fff;
   localparam logic [15:0] SAMPLE_MIN = 16'h8000;
   localparam logic [15:0] AMP_FULL   = 16'h8000;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVEFORM_SELECT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_OFFSET    = 2'd2;

   // Waveform selector codes; the remaining codes give silence
   localparam logic [2:0] WAVE_SINE     = 3'd0;
   localparam logic [2:0] WAVE_SQUARE   = 3'd1;
   localparam logic [2:0] WAVE_SAW      = 3'd2;
   localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
   localparam logic [2:0] WAVE_NOISE    = 3'd4;

   typedef logic [PHASE_BITS-1:0] phase_type;
   typedef logic signed [16:0]    wave_type;
   typedef logic [15:0]           sine_rom_type [SINE_QUARTER_DEPTH];

   // Word handed from the phase stage to the wave stage
   typedef struct packed {
      phase_type   phase;
      logic [15:0] noise;
   } phase_word_type;

   // Bring a 32-bit phase quantity onto the accumulator grid
   function automatic phase_type align32(logic [31:0] v);
      logic [PHASE_BITS+31:0] w;
      w = {v, {PHASE_BITS{1'b0}}};
      return w[PHASE_BITS+31:32];
   endfunction

   // One table entry: Q30 Taylor series through the 11th power, rounded to Q15
   function automatic logic [15:0] sine_entry(int unsigned i);
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] t;
      logic [63:0] s;
      a  = (HALF_PI_Q30 * 64'(i)) / SINE_QUARTER_DEPTH;
      a2 = (a * a) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((a2 * t) >> 30) / 110;
      t  = ONE_Q30 - ((a2 * t) >> 30) / 72;
      t  = ONE_Q30 - ((a2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((a2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((a2 * t) >> 30) / 6;
      s  = (a * t) >> 30;
      s  = (s + 64'd16384) >> 15;
      return (s > 64'd32767) ? SAMPLE_MAX : s[15:0];
   endfunction

   function automatic sine_rom_type sine_rom_init();
      sine_rom_type rom;
      for (int unsigned i = 0; i < SINE_QUARTER_DEPTH; i++) begin
         rom[i] = sine_entry(i);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = sine_rom_init();

endpackage

[hdl/mwo_phase.sv]
// Phase accumulator and noise LFSR stage of the oscillator.
module mwo_phase import mwo_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [31:0]    freq_step,
   input  logic           note_start,
   output logic           out_valid,
   input  logic           out_ready,
   output phase_word_type out_word
);

   phase_type      phase_ff, phase_in;
   logic [31:0]    lfsr_ff, lfsr_in;
   logic           valid_ff, valid_in;
   phase_word_type word_ff, word_in;
   phase_type      phase_now;
   logic           in_fire;

   assign in_ready = !valid_ff || out_ready;
   assign in_fire  = in_valid && in_ready;

   // Phase seen by this word: note start clears it first
   assign phase_now = note_start ? '0 : phase_ff;

   // Next accumulator, LFSR and stage word
   always_comb begin
      phase_in = phase_ff;
      lfsr_in  = lfsr_ff;
      if (in_fire) begin
         phase_in = phase_now + align32(freq_step);
         lfsr_in  = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LFSR_TAPS) : (lfsr_ff >> 1);
      end
      word_in.phase = phase_now;
      word_in.noise = lfsr_in[31:16];
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         lfsr_ff  <= LFSR_SEED;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         lfsr_ff  <= lfsr_in;
         valid_ff <= valid_in;
      end
   end

   // Payload register, loaded on accept
   always_ff @(posedge clock) begin
      if (in_fire) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

`ifndef ASSERT_OFF
   // LFSR must never lock up in the all-zero state
   assert property (@(posedge clock) disable iff (reset) lfsr_ff != '0)
      else $error("noise LFSR reached zero");
`endif

endmodule

[hdl/mwo_wave.sv]
// Waveform shaping stage: sine table, square, saw, triangle and noise.
module mwo_wave import mwo_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic [2:0]     waveform_select,
   input  logic [31:0]    phase_offset,
   input  logic           in_valid,
   output logic           in_ready,
   input  phase_word_type in_word,
   output logic           out_valid,
   input  logic           out_ready,
   output wave_type       out_wave
);

   logic                  valid_ff, valid_in;
   wave_type              wave_ff, wave_in;
   logic [15:0]           frac16;
   phase_type             sine_phase;
   logic [1:0]            quad;
   logic [SINE_IDX_W-1:0] idx, rom_addr;
   logic [15:0]           sine_mag;
   wave_type              sine_wave;
   logic [16:0]           tri_d;
   logic [17:0]           tri_w;
   logic                  in_fire;

   assign in_ready = !valid_ff || out_ready;
   assign in_fire  = in_valid && in_ready;

   assign frac16 = in_word.phase[PHASE_BITS-1 -: 16];

   // Sine: quadrant from the offset phase, mirrored index on odd quadrants
   assign sine_phase = in_word.phase + align32(phase_offset);
   assign quad       = sine_phase[PHASE_BITS-1 -: 2];
   assign idx        = sine_phase[PHASE_BITS-3 -: SINE_IDX_W];
   assign rom_addr   = quad[0] ? (SINE_IDX_W'(0) - idx) : idx;
   assign sine_mag   = (quad[0] && (idx == '0)) ? SAMPLE_MAX : SINE_ROM[rom_addr];
   assign sine_wave  = quad[1] ? -wave_type'({1'b0, sine_mag}) : wave_type'({1'b0, sine_mag});

   // Triangle: fold the upper half, then 2*d - 1.0
   assign tri_d = frac16[15] ? (17'h10000 - {1'b0, frac16}) : {1'b0, frac16};
   assign tri_w = {tri_d, 1'b0} - 18'sd32768;

   always_comb begin
      unique case (waveform_select)
         WAVE_SINE:     wave_in = sine_wave;
         WAVE_SQUARE:   wave_in = frac16[15] ? 17'sd32768 : -17'sd32768;
         WAVE_SAW:      wave_in = wave_type'({1'b0, frac16}) - 17'sd32768;
         WAVE_TRIANGLE: wave_in = tri_w[16:0];
         WAVE_NOISE:    wave_in = wave_type'({1'b0, in_word.noise}) - 17'sd32768;
         default:       wave_in = '0;
      endcase
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         wave_ff <= wave_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_wave  = wave_ff;

`ifndef ASSERT_OFF
   // Every shape stays within plus or minus full scale
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (wave_ff >= -17'sd32768 && wave_ff <= 17'sd32768))
      else $error("wave value outside full scale");
`endif

endmodule

[hdl/mwo_scale.sv]
// Amplitude scaling and saturation stage driving the result register.
module mwo_scale import mwo_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] amplitude,
   input  logic        in_valid,
   output logic        in_ready,
   input  wave_type    in_wave,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [15:0] out_sample
);

   logic               valid_ff, valid_in;
   logic [15:0]        sample_ff, sample_in;
   logic signed [33:0] prod;
   logic [17:0]        scaled;
   logic               in_fire;

   assign in_ready = !valid_ff || out_ready;
   assign in_fire  = in_valid && in_ready;

   // Floor of wave * amplitude / 2^15 is an arithmetic shift
   assign prod   = 34'(in_wave) * 34'($signed({1'b0, amplitude}));
   assign scaled = prod[32:15];

   // Saturate to Q1.15
   always_comb begin
      if ((scaled[17:15] == 3'b000) || (scaled[17:15] == 3'b111)) begin
         sample_in = scaled[15:0];
      end else begin
         sample_in = scaled[17] ? SAMPLE_MIN : SAMPLE_MAX;
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         sample_ff <= sample_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_sample = sample_ff;

`ifndef ASSERT_OFF
   // Below full scale the product never needs saturation
   assert property (@(posedge clock) disable iff (reset)
      (in_fire && amplitude < AMP_FULL) |->
         ((scaled[17:15] == 3'b000) || (scaled[17:15] == 3'b111)))
      else $error("saturation hit below full-scale amplitude");
`endif

endmodule

[hdl/multi_waveform_oscillator_core.sv]
// Top level of the multi-waveform oscillator: CSRs and the three-stage pipe.
//
// Usage:
//   Request channel (req_valid/req_ready): one word per sample tick with the
//   32-bit phase step and a note-start flag that zeroes the phase first.
//   Response channel (rsp_valid/rsp_ready): one signed Q1.15 sample per
//   request word, in order.
//   CSR port: csr_we writes csr_wdata to register csr_index at the clock
//   edge (0 waveform select, 1 amplitude, 2 phase offset); write only while
//   the pipe is empty.
// Order: an accepted word passes the phase, wave and scale registers in turn
//   before its sample shows on rsp_valid. Throughput: one word per cycle
//   while rsp_ready is high; the pipe is phase accumulator/LFSR, waveform
//   shaping with the sine table, then the amplitude multiplier.
// Reset: phase zero, LFSR seed 1, sine waveform at full-scale amplitude,
//   zero phase offset, pipe empty.
// Stall: with rsp_ready low the pipe fills its three registers and then
//   drops req_ready; no word is lost or repeated.
module multi_waveform_oscillator_core import mwo_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [31:0]          req_freq_step,
   input  logic                 req_note_start,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [15:0]   rsp_sample_out,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   logic [2:0]     waveform_select_ff, waveform_select_in;
   logic [15:0]    amplitude_ff, amplitude_in;
   logic [31:0]    phase_offset_ff, phase_offset_in;

   logic           ph_valid, ph_ready;
   phase_word_type ph_word;
   logic           wv_valid, wv_ready;
   wave_type       wv_wave;
   logic [15:0]    sample;

   // CSR write decode
   always_comb begin
      waveform_select_in = waveform_select_ff;
      amplitude_in       = amplitude_ff;
      phase_offset_in    = phase_offset_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WAVEFORM_SELECT: waveform_select_in = csr_wdata[2:0];
            CSR_AMPLITUDE:       amplitude_in       = csr_wdata[15:0];
            CSR_PHASE_OFFSET:    phase_offset_in    = csr_wdata;
            default:             ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_select_ff <= WAVE_SINE;
         amplitude_ff       <= AMP_FULL;
         phase_offset_ff    <= '0;
      end else begin
         waveform_select_ff <= waveform_select_in;
         amplitude_ff       <= amplitude_in;
         phase_offset_ff    <= phase_offset_in;
      end
   end

   mwo_phase u_phase (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .freq_step  (req_freq_step),
      .note_start (req_note_start),
      .out_valid  (ph_valid),
      .out_ready  (ph_ready),
      .out_word   (ph_word)
   );

   mwo_wave u_wave (
      .clock           (clock),
      .reset           (reset),
      .waveform_select (waveform_select_ff),
      .phase_offset    (phase_offset_ff),
      .in_valid        (ph_valid),
      .in_ready        (ph_ready),
      .in_word         (ph_word),
      .out_valid       (wv_valid),
      .out_ready       (wv_ready),
      .out_wave        (wv_wave)
   );

   mwo_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .amplitude  (amplitude_ff),
      .in_valid   (wv_valid),
      .in_ready   (wv_ready),
      .in_wave    (wv_wave),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_sample (sample)
   );

   assign rsp_sample_out = $signed(sample);

`ifndef ASSERT_OFF
   // A draining output frees the whole pipe, so requests are never blocked
   assert property (@(posedge clock) disable iff (reset) rsp_ready |-> req_ready)
      else $error("request stalled while response side is ready");
`endif

endmodule

[tb/tb_multi_waveform_oscillator_core.sv]
// Self-checking testbench of the oscillator core: predicted samples checked word by word.
`timescale 1ns / 100ps

module tb_multi_waveform_oscillator_core;
   import mwo_pkg::*;

   localparam int          WATCHDOG_LIMIT  = 3000;
   localparam int          HOLD_CYCLES     = 300;
   localparam int          DRAIN_CYCLES    = 8;
   localparam int          PHASE_COUNT     = 20;
   localparam int          WORDS_PER_PHASE = 52;
   localparam logic [31:0] NOISE_FEEDBACK  = 32'h8020_0003;
   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

   // Oscillator prediction and sample store
   class osc_scoreboard;
      int unsigned        quarter_sine [SINE_QUARTER_DEPTH];
      longint unsigned    phase;
      logic [31:0]        noise;
      logic [2:0]         wave_sel;
      logic [15:0]        amp_level;
      logic [31:0]        sine_offset;
      logic signed [15:0] expected_samples [$];
      int                 mismatches;

      function new();
         longint unsigned ang;
         longint unsigned ang_sq;
         longint unsigned series;
         longint unsigned s;
         int                divisors [5] = '{110, 72, 42, 20, 6};
         // Quarter sine by a Q30 Taylor series, rounded to Q15
         for (int i = 0; i < SINE_QUARTER_DEPTH; i++) begin
            ang    = (QUARTER_TURN_Q30 * longint'(i)) / SINE_QUARTER_DEPTH;
            ang_sq = (ang * ang) >> 30;
            series = 64'd1 << 30;
            foreach (divisors[k])
               series = (64'd1 << 30) - ((ang_sq * series) >> 30) / divisors[k];
            s = (((ang * series) >> 30) + 64'd16384) >> 15;
            quarter_sine[i] = (s > 32767) ? 32767 : int'(s);
         end
         phase       = 0;
         noise       = 32'd1;
         wave_sel    = WAVE_SINE;
         amp_level   = 16'd32768;
         sine_offset = '0;
         mismatches  = 0;
      endfunction

      function longint unsigned phase_mask();
         return (64'd1 << PHASE_BITS) - 1;
      endfunction

      // 32-bit step or offset onto the accumulator grid
      function longint unsigned on_grid(logic [31:0] v);
         if (PHASE_BITS >= 32)
            return (longint'(v) << (PHASE_BITS - 32)) & phase_mask();
         return longint'(v) >> (32 - PHASE_BITS);
      endfunction

      function int sine_at(longint unsigned p);
         longint unsigned quad;
         longint unsigned pos;
         longint unsigned qmask;
         int                v;
         quad  = (p >> (PHASE_BITS - 2)) & 3;
         qmask = (64'd1 << (PHASE_BITS - 2)) - 1;
         pos   = ((p & qmask) * SINE_QUARTER_DEPTH) >> (PHASE_BITS - 2);
         // odd quadrants run the table backwards; the top position is full scale
         if (quad[0])
            pos = SINE_QUARTER_DEPTH - pos;
         v = (pos >= SINE_QUARTER_DEPTH) ? 32767 : int'(quarter_sine[pos]);
         return quad[1] ? -v : v;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
         case (idx)
            CSR_WAVEFORM_SELECT: wave_sel    = data[2:0];
            CSR_AMPLITUDE:       amp_level   = data[15:0];
            CSR_PHASE_OFFSET:    sine_offset = data;
            default: ;
         endcase
      endfunction

      function logic signed [15:0] predict_sample(logic [31:0] step, logic start);
         longint unsigned p;
         int              frac16;
         int              wave;
         int              d;
         longint          prod;
         if (start)
            phase = 0;
         p      = phase & phase_mask();
         frac16 = int'((p >> (PHASE_BITS - 16)) & 64'hFFFF);
         // LFSR advances on every tick
         noise = noise[0] ? ((noise >> 1) ^ NOISE_FEEDBACK) : (noise >> 1);
         case (wave_sel)
            WAVE_SINE:     wave = sine_at((p + on_grid(sine_offset)) & phase_mask());
            WAVE_SQUARE:   wave = (frac16 < 32768) ? -32768 : 32768;
            WAVE_SAW:      wave = frac16 - 32768;
            WAVE_TRIANGLE: begin
               d    = (frac16 < 32768) ? frac16 : 65536 - frac16;
               wave = 2 * d - 32768;
            end
            WAVE_NOISE:    wave = int'(noise >> 16) - 32768;
            default:       wave = 0;
         endcase
         // floor scaling and saturation
         prod = (longint'(wave) * longint'(amp_level)) >>> 15;
         if (prod > 32767)
            prod = 32767;
         else if (prod < -32768)
            prod = -32768;
         phase = (p + on_grid(step)) & phase_mask();
         return prod[15:0];
      endfunction

      function void note_word(logic [31:0] step, logic start);
         expected_samples.push_back(predict_sample(step, start));
      endfunction

      function void check_sample(logic signed [15:0] actual);
         logic signed [15:0] want;
         if (expected_samples.size() == 0) begin
            $error("sample_out: expected none, actual %0d", actual);
            mismatches++;
         end else begin
            want = expected_samples.pop_front();
            if (actual !== want) begin
               $error("sample_out: expected %0d, actual %0d", want, actual);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic [31:0]          req_freq_step  = '0;
   logic                 req_note_start = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic signed [15:0]   rsp_sample_out;
   logic                 csr_we         = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = CSR_WAVEFORM_SELECT;
   logic [31:0]          csr_wdata      = '0;

   osc_scoreboard board;
   int            send_idle_pct  = 0;
   int            recv_stall_pct = 0;
   bit            hold_request   = 1'b0;
   int            hold_left      = 0;
   int            quiet_cycles   = 0;

   multi_waveform_oscillator_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_freq_step  (req_freq_step),
      .req_note_start (req_note_start),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   // Receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Handshakes sampled mid-cycle, where all inputs and outputs are settled
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_word(req_freq_step, req_note_start);
         if (rsp_valid && rsp_ready)
            board.check_sample(rsp_sample_out);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[multi_waveform_oscillator_core] ERROR");
            $finish;
         end
      end
   end

   // Offer one word, with random idle cycles first; returns after the accepting edge
   task automatic send_word(input logic [31:0] step, input logic start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_freq_step  <= step;
      req_note_start <= start;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   // Wait for every predicted sample, then let the pipe settle
   task automatic drain;
      req_valid <= 1'b0;
      while (board.expected_samples.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input logic [2:0] sel, input logic [15:0] amp,
                                 input logic [31:0] offset);
      csr_we    <= 1'b1;
      csr_index <= CSR_WAVEFORM_SELECT;
      csr_wdata <= 32'(sel);
      board.write_reg(CSR_WAVEFORM_SELECT, 32'(sel));
      @(posedge clock);
      csr_index <= CSR_AMPLITUDE;
      csr_wdata <= 32'(amp);
      board.write_reg(CSR_AMPLITUDE, 32'(amp));
      @(posedge clock);
      csr_index <= CSR_PHASE_OFFSET;
      csr_wdata <= offset;
      board.write_reg(CSR_PHASE_OFFSET, offset);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] random_step();
      case ($urandom_range(9))
         0:       return '0;
         1:       return 32'hFFFF_FFFF;
         2, 3, 4: return $urandom_range(32'h00FF_FFFF);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] random_amp();
      case ($urandom_range(5))
         0:       return 16'd0;
         1:       return 16'd32768;
         2:       return 16'hFFFF;
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   function automatic logic [31:0] random_offset();
      case ($urandom_range(4))
         0:       return '0;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [15:0] amp_list [8];
      logic [2:0]  sel;
      amp_list = '{16'd32768, 16'hFFFF, 16'd1, 16'd32767,
                   16'd32768, 16'd0, 16'hFFFF, 16'd32768};
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: every selector code, a quadrant edge, amplitude extremes
      for (int s = 0; s < 8; s++) begin
         write_settings(3'(s), amp_list[s], (s == 0) ? 32'h0 : 32'hFFFF_FFFF);
         send_word(32'h4000_0000, 1'b1);
         send_word(32'hFFFF_FFFF, 1'b0);
         send_word(32'h0000_0000, 1'b0);
         drain();
      end

      // Random phases, cycling through the idle/stall mixes
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         sel = ($urandom_range(7) == 0) ? 3'($urandom_range(7, 5))
                                        : 3'($urandom_range(4));
         write_settings(sel, random_amp(), random_offset());
         // long receiver hold-off while the sender keeps offering
         if (ph == 4)
            hold_request = 1'b1;
         for (int n = 0; n < WORDS_PER_PHASE; n++)
            send_word(random_step(), $urandom_range(15) == 0);
         drain();
      end

      if (board.mismatches == 0)
         $display("[multi_waveform_oscillator_core] OK");
      else
         $display("[multi_waveform_oscillator_core] ERROR");
      $finish;
   end

endmodule
